FILE: hdl/mtlp_pkg.sv
// ----------------------------------------------------------------------------
// mtlp_pkg
// Shared types, constants and prefix tables of the meter telegram line parser.
// ----------------------------------------------------------------------------
package mtlp_pkg;

  // Line buffer limit: bytes past LINE_BYTES-1 in one line are dropped.
  localparam int LINE_BYTES = 512;
  localparam int POS_W      = $clog2(LINE_BYTES);
  localparam logic [POS_W-1:0] LINE_LIMIT = POS_W'(LINE_BYTES - 1);

  localparam int READING_COUNT = 17;
  localparam int GAS_READING   = 16;
  localparam int PREFIX_CHARS  = 11;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [47:0] MAG_CAP = 48'h8000_0000_0000;
  localparam logic [47:0] MAX_POS = 48'h7FFF_FFFF_FFFF;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;

  // Ten-character prefixes carry a pad byte that the length table masks off.
  localparam logic [8*PREFIX_CHARS-1:0] PREFIX_TEXT [READING_COUNT] = '{
    "1-0:1.7.0( ",  "1-0:2.7.0( ",  "1-0:21.7.0(", "1-0:22.7.0(",
    "1-0:41.7.0(",  "1-0:42.7.0(",  "1-0:61.7.0(", "1-0:62.7.0(",
    "1-0:32.7.0(",  "1-0:52.7.0(",  "1-0:72.7.0(",
    "1-0:31.7.0(",  "1-0:51.7.0(",  "1-0:71.7.0(",
    "1-0:1.8.0( ",  "1-0:2.8.0( ",  "0-1:24.2.1("
  };

  localparam logic [3:0] PREFIX_LEN [READING_COUNT] = '{
    4'd10, 4'd10, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11,
    4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd11, 4'd10, 4'd10, 4'd11
  };

  typedef enum logic [3:0] {
    K_NEWLINE,
    K_ZERO,
    K_DIGIT,
    K_POINT,
    K_PLUS,
    K_MINUS,
    K_OPEN,
    K_CLOSE,
    K_BLANK,
    K_OTHER
  } kind_t;

  typedef enum logic [2:0] {
    PH_MATCH,
    PH_STAMP_FIRST,
    PH_STAMP_REST,
    PH_OPEN,
    PH_BLANKS,
    PH_INT,
    PH_FRAC,
    PH_END
  } phase_t;

  // One classified byte as handed from the front to the back.
  typedef struct packed {
    kind_t                    kind;
    logic [3:0]               digit;
    logic [READING_COUNT-1:0] hit;
    logic [READING_COUNT-1:0] fin;
  } item_t;

  function automatic logic [7:0] prefix_char(input logic [8*PREFIX_CHARS-1:0] text,
                                             input logic [3:0] pos);
    logic [7:0] c;
    c = 8'h00;
    for (int p = 0; p < PREFIX_CHARS; p++) begin
      if (pos == 4'(p)) begin
        c = text[8*(PREFIX_CHARS-1-p) +: 8];
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/mtlp_front.sv
// ----------------------------------------------------------------------------
// mtlp_front
// Counts line position, drops overlong bytes and classifies each byte,
// including its agreement with every reading prefix at the current position.
// ----------------------------------------------------------------------------
module mtlp_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic [7:0]     rx_byte,
  output logic           push,
  output mtlp_pkg::item_t item
);

  logic [mtlp_pkg::POS_W-1:0] pos_r;
  logic [mtlp_pkg::POS_W-1:0] pos_nxt;
  logic                       is_newline;
  logic                       keep_byte;
  logic [3:0]                 pos_small;

  assign is_newline = (rx_byte == mtlp_pkg::CH_NEWLINE);
  assign keep_byte  = (pos_r < mtlp_pkg::LINE_LIMIT);
  assign push       = accept && (is_newline || keep_byte);

  // Prefix matching only looks at the first few positions of a line.
  assign pos_small = (pos_r < mtlp_pkg::POS_W'(mtlp_pkg::PREFIX_CHARS)) ?
                     pos_r[3:0] : 4'hF;

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (is_newline) begin
        pos_nxt = '0;
      end else if (keep_byte) begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    item.digit = 4'(rx_byte - mtlp_pkg::CH_ZERO);
    priority if (is_newline) begin
      item.kind = mtlp_pkg::K_NEWLINE;
    end else if (rx_byte == mtlp_pkg::CH_NUL) begin
      item.kind = mtlp_pkg::K_ZERO;
    end else if (rx_byte >= mtlp_pkg::CH_ZERO && rx_byte <= mtlp_pkg::CH_NINE) begin
      item.kind = mtlp_pkg::K_DIGIT;
    end else if (rx_byte == mtlp_pkg::CH_POINT) begin
      item.kind = mtlp_pkg::K_POINT;
    end else if (rx_byte == mtlp_pkg::CH_PLUS) begin
      item.kind = mtlp_pkg::K_PLUS;
    end else if (rx_byte == mtlp_pkg::CH_MINUS) begin
      item.kind = mtlp_pkg::K_MINUS;
    end else if (rx_byte == mtlp_pkg::CH_OPEN) begin
      item.kind = mtlp_pkg::K_OPEN;
    end else if (rx_byte == mtlp_pkg::CH_CLOSE) begin
      item.kind = mtlp_pkg::K_CLOSE;
    end else if (rx_byte == mtlp_pkg::CH_SPACE ||
                 (rx_byte >= mtlp_pkg::CH_TAB && rx_byte <= mtlp_pkg::CH_CR)) begin
      item.kind = mtlp_pkg::K_BLANK;
    end else begin
      item.kind = mtlp_pkg::K_OTHER;
    end
    for (int k = 0; k < mtlp_pkg::READING_COUNT; k++) begin
      item.hit[k] = (pos_small < mtlp_pkg::PREFIX_LEN[k]) &&
                    (rx_byte == mtlp_pkg::prefix_char(mtlp_pkg::PREFIX_TEXT[k], pos_small));
      item.fin[k] = item.hit[k] && (pos_small == mtlp_pkg::PREFIX_LEN[k] - 4'd1);
    end
  end

endmodule

FILE: hdl/mtlp_queue.sv
// ----------------------------------------------------------------------------
// mtlp_queue
// Small first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module mtlp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mtlp_pkg::item_t push_item,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output mtlp_pkg::item_t head
);

  mtlp_pkg::item_t                    mem_r [mtlp_pkg::QUEUE_DEPTH];
  logic [mtlp_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [mtlp_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [mtlp_pkg::QCNT_W-1:0]        count_r;
  logic [mtlp_pkg::QCNT_W-1:0]        count_nxt;

  assign full      = (count_r == mtlp_pkg::QCNT_W'(mtlp_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

endmodule

FILE: hdl/mtlp_back.sv
// ----------------------------------------------------------------------------
// mtlp_back
// Line parse state machine, decimal accumulator and the two-stage scaling
// path that turns a finished line into a reading.
// ----------------------------------------------------------------------------
module mtlp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  mtlp_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_metric_id,
  output logic signed [47:0] out_value_milli
);

  localparam int RC = mtlp_pkg::READING_COUNT;

  mtlp_pkg::phase_t phase_r, phase_nxt;
  logic [RC-1:0]    alive_r, alive_nxt;
  logic [47:0]      acc_r, acc_nxt;
  logic [1:0]       frac_r, frac_nxt;
  logic             neg_r, neg_nxt;
  logic             seen_r, seen_nxt;
  logic [4:0]       matched_r, matched_nxt;

  logic [RC-1:0]    keep;
  logic             done;
  logic [4:0]       done_idx;
  logic             is_gas;
  logic [51:0]      acc_step_wide;
  logic [47:0]      acc_step;
  logic             res_load;

  logic             p1_valid_r;
  logic [4:0]       p1_metric_r;
  logic             p1_neg_r;
  logic [57:0]      p1_prod_r;
  logic [9:0]       scale;
  logic             out_load;
  logic             p1_free;
  logic [47:0]      mag;
  logic [47:0]      val;

  logic             out_valid_r;
  logic [4:0]       out_metric_r;
  logic [47:0]      out_value_r;

  assign out_load = p1_valid_r && (!out_valid_r || !out_stall);
  assign p1_free  = !p1_valid_r || out_load;
  assign q_pop    = q_valid && p1_free;

  // Prefix survivors and the first completed prefix; the highest index wins.
  always_comb begin
    keep     = alive_r & q_item.hit;
    done     = 1'b0;
    done_idx = '0;
    for (int k = 0; k < RC; k++) begin
      if (keep[k] && q_item.fin[k]) begin
        done     = 1'b1;
        done_idx = 5'(k);
      end
    end
  end

  assign is_gas = (done_idx == 5'(mtlp_pkg::GAS_READING));

  // Magnitude times ten plus digit, held at the cap.
  assign acc_step_wide = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + {48'd0, q_item.digit};
  assign acc_step      = (acc_step_wide > {4'd0, mtlp_pkg::MAG_CAP}) ?
                         mtlp_pkg::MAG_CAP : acc_step_wide[47:0];

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (q_pop) begin
      if (q_item.kind == mtlp_pkg::K_NEWLINE) begin
        phase_nxt = mtlp_pkg::PH_MATCH;
      end else begin
        unique case (phase_r)
          mtlp_pkg::PH_MATCH: begin
            if (done) begin
              phase_nxt = is_gas ? mtlp_pkg::PH_STAMP_FIRST : mtlp_pkg::PH_BLANKS;
            end else if (keep == '0) begin
              phase_nxt = mtlp_pkg::PH_END;
            end
          end
          mtlp_pkg::PH_STAMP_FIRST: begin
            phase_nxt = (q_item.kind == mtlp_pkg::K_CLOSE ||
                         q_item.kind == mtlp_pkg::K_ZERO) ?
                        mtlp_pkg::PH_END : mtlp_pkg::PH_STAMP_REST;
          end
          mtlp_pkg::PH_STAMP_REST: begin
            if (q_item.kind == mtlp_pkg::K_CLOSE) begin
              phase_nxt = mtlp_pkg::PH_OPEN;
            end else if (q_item.kind == mtlp_pkg::K_ZERO) begin
              phase_nxt = mtlp_pkg::PH_END;
            end
          end
          mtlp_pkg::PH_OPEN: begin
            phase_nxt = (q_item.kind == mtlp_pkg::K_OPEN) ?
                        mtlp_pkg::PH_BLANKS : mtlp_pkg::PH_END;
          end
          mtlp_pkg::PH_BLANKS: begin
            unique case (q_item.kind)
              mtlp_pkg::K_BLANK: phase_nxt = mtlp_pkg::PH_BLANKS;
              mtlp_pkg::K_PLUS,
              mtlp_pkg::K_MINUS,
              mtlp_pkg::K_DIGIT: phase_nxt = mtlp_pkg::PH_INT;
              mtlp_pkg::K_POINT: phase_nxt = mtlp_pkg::PH_FRAC;
              default:           phase_nxt = mtlp_pkg::PH_END;
            endcase
          end
          mtlp_pkg::PH_INT: begin
            unique case (q_item.kind)
              mtlp_pkg::K_DIGIT: phase_nxt = mtlp_pkg::PH_INT;
              mtlp_pkg::K_POINT: phase_nxt = mtlp_pkg::PH_FRAC;
              default:           phase_nxt = mtlp_pkg::PH_END;
            endcase
          end
          mtlp_pkg::PH_FRAC: begin
            if (q_item.kind != mtlp_pkg::K_DIGIT) begin
              phase_nxt = mtlp_pkg::PH_END;
            end
          end
          mtlp_pkg::PH_END: phase_nxt = mtlp_pkg::PH_END;
          default:          phase_nxt = mtlp_pkg::PH_END;
        endcase
      end
    end
  end

  // Line datapath.
  always_comb begin
    alive_nxt   = alive_r;
    acc_nxt     = acc_r;
    frac_nxt    = frac_r;
    neg_nxt     = neg_r;
    seen_nxt    = seen_r;
    matched_nxt = matched_r;
    res_load    = 1'b0;
    if (q_pop) begin
      if (q_item.kind == mtlp_pkg::K_NEWLINE) begin
        res_load    = seen_r;
        alive_nxt   = '1;
        acc_nxt     = '0;
        frac_nxt    = '0;
        neg_nxt     = 1'b0;
        seen_nxt    = 1'b0;
        matched_nxt = '0;
      end else begin
        unique case (phase_r)
          mtlp_pkg::PH_MATCH: begin
            alive_nxt = keep;
            if (done) begin
              matched_nxt = done_idx;
            end
          end
          mtlp_pkg::PH_BLANKS: begin
            if (q_item.kind == mtlp_pkg::K_MINUS) begin
              neg_nxt = 1'b1;
            end else if (q_item.kind == mtlp_pkg::K_DIGIT) begin
              acc_nxt  = acc_step;
              seen_nxt = 1'b1;
            end
          end
          mtlp_pkg::PH_INT: begin
            if (q_item.kind == mtlp_pkg::K_DIGIT) begin
              acc_nxt  = acc_step;
              seen_nxt = 1'b1;
            end
          end
          mtlp_pkg::PH_FRAC: begin
            // Digits past the third fraction digit are read but not kept.
            if (q_item.kind == mtlp_pkg::K_DIGIT) begin
              seen_nxt = 1'b1;
              if (frac_r != 2'd3) begin
                acc_nxt  = acc_step;
                frac_nxt = frac_r + 2'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= mtlp_pkg::PH_MATCH;
      alive_r   <= '1;
      acc_r     <= '0;
      frac_r    <= '0;
      neg_r     <= 1'b0;
      seen_r    <= 1'b0;
      matched_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      alive_r   <= alive_nxt;
      acc_r     <= acc_nxt;
      frac_r    <= frac_nxt;
      neg_r     <= neg_nxt;
      seen_r    <= seen_nxt;
      matched_r <= matched_nxt;
    end
  end

  // Missing fraction digits are made up by one multiply by a power of ten.
  always_comb begin
    unique case (frac_r)
      2'd0: scale = 10'd1000;
      2'd1: scale = 10'd100;
      2'd2: scale = 10'd10;
      2'd3: scale = 10'd1;
      default: scale = 10'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (res_load) begin
      p1_valid_r <= 1'b1;
    end else if (out_load) begin
      p1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      p1_metric_r <= matched_r;
      p1_neg_r    <= neg_r;
      p1_prod_r   <= {10'd0, acc_r} * {48'd0, scale};
    end
  end

  assign mag = (p1_prod_r > {10'd0, mtlp_pkg::MAG_CAP}) ? mtlp_pkg::MAG_CAP : p1_prod_r[47:0];
  assign val = p1_neg_r ? (48'd0 - mag) :
               ((mag > mtlp_pkg::MAX_POS) ? mtlp_pkg::MAX_POS : mag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_metric_r <= p1_metric_r;
      out_value_r  <= val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_metric_id   = out_metric_r;
  assign out_value_milli = $signed(out_value_r);

endmodule

FILE: hdl/meter_telegram_line_parser.sv
// ----------------------------------------------------------------------------
// meter_telegram_line_parser
// Smart-meter telegram line parser: one reading per recognized line.
// ----------------------------------------------------------------------------
// The block takes one telegram byte per cycle while in_stall is low and
// reports, at each newline that closes a recognized reading line with at
// least one digit, the reading number and its value in thousandths of the
// unit (watts for kW lines). A front stage classifies each byte and checks
// it against all prefixes at the current line position, a four-entry queue
// follows, and a back stage runs the parse and a two-stage scale and
// saturate path. Throughput is one byte per cycle while results are taken;
// with an empty queue a reading is offered once its newline has passed
// through the queue and the multiply stage, which loads the output register.
module meter_telegram_line_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [4:0]         out_metric_id,
  output logic signed [47:0] out_value_milli
);

  logic            in_accept;
  logic            q_push;
  mtlp_pkg::item_t q_push_item;
  logic            q_pop;
  logic            q_full;
  logic            q_valid;
  mtlp_pkg::item_t q_head;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  mtlp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .rx_byte (in_rx_byte),
    .push    (q_push),
    .item    (q_push_item)
  );

  mtlp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_push_item),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  mtlp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_metric_id   (out_metric_id),
    .out_value_milli (out_value_milli)
  );

  a_metric_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_metric_id <= 5'd16))
    else $error("reading number out of range");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> q_valid)
    else $error("queue empty after a push");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("queue written while full");

endmodule
